FILE: src/int16_multiply_requantize_defines.svh
// Assertion macros for the int16 multiply-requantize block.
// Taken in by the checker module; no other dependencies.
`ifndef INT16_MULTIPLY_REQUANTIZE_DEFINES_SVH
`define INT16_MULTIPLY_REQUANTIZE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define IMR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imr: implication check failed");

// Implication with a fixed delay in cycles, disabled while in reset.
`define IMR_ASSERT_DELAY(label, ante, dly, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error("imr: delayed check failed");

`endif

FILE: src/imr_pkg.sv
// Shared types and constants for the int16 multiply-requantize block.
// No dependencies.
package imr_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int LATENCY     = 5;

    localparam logic [CFG_INDEX_W-1:0] REG_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MULT  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SHIFT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZP    = 2'd3;

    localparam logic               MODE_SHIFT16 = 1'b0;
    localparam logic               MODE_MULT8   = 1'b1;
    localparam logic signed [31:0] MULT_RESET   = 32'sh4000_0000;

    typedef struct packed {
        logic signed [15:0] lhs;
        logic signed [15:0] rhs;
        logic               last_in;
    } operand_t;

    typedef struct packed {
        logic signed [15:0] product_out;
        logic               last_out;
    } result_t;

endpackage

FILE: src/int16_multiply_requantize.sv
// Top level of the int16 multiply-requantize block: five-stage pipeline.
// Depends on imr_pkg.
//
// One element pair is taken on every cycle that start is high; busy never rises.
// Each result appears on result with result_valid high for exactly one cycle,
// in the order its operands were taken. Stages: 16x16 multiply,
// rounding shift or wrapping left shift, 32x32 Q31 multiply, rounding right
// shift, zero point add and saturate. cfg_ready is always high; write the
// registers only while no results are outstanding.
module int16_multiply_requantize (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  imr_pkg::operand_t                 operand,
    output logic                              result_valid,
    output imr_pkg::result_t                  result,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [imr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import imr_pkg::*;

    logic               mode_reg;
    logic signed [31:0] mult_reg;
    logic signed [5:0]  shift_reg;
    logic signed [7:0]  zp_reg;

    logic               v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic               l1_reg, l2_reg, l3_reg, l4_reg, l5_reg;
    logic               m1_reg, m2_reg, m3_reg, m4_reg;
    logic signed [31:0] p1_reg;
    logic signed [31:0] x2_reg, x2_next;
    logic signed [15:0] r2_reg, r2_next, r3_reg, r4_reg;
    logic signed [63:0] mul3_reg, mul3_next;
    logic               sat3_reg;
    logic signed [31:0] q4_reg, q4_next;
    result_t            out_reg, out_next;

    logic [4:0]         s0;
    logic signed [32:0] rnd0, sum0, shr0;
    logic [4:0]         left;
    logic [5:0]         neg_shift;
    logic [4:0]         right;
    logic signed [63:0] sum64;
    logic signed [31:0] q;
    logic signed [32:0] rnd1, sum1, shr1;
    logic signed [31:0] w5;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_SHIFT16;
            mult_reg  <= MULT_RESET;
            shift_reg <= 6'sd0;
            zp_reg    <= 8'sd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_MULT:  mult_reg  <= cfg_data[31:0];
                REG_SHIFT: shift_reg <= cfg_data[5:0];
                REG_ZP:    zp_reg    <= cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        s0      = shift_reg[4:0];
        rnd0    = (s0 == 5'd0) ? 33'sd0 : (33'sd1 <<< (s0 - 5'd1));
        sum0    = {p1_reg[31], p1_reg} + rnd0;
        shr0    = sum0 >>> s0;
        if (shr0 > 33'sd32767)
            r2_next = 16'sh7FFF;
        else if (shr0 < -33'sd32768)
            r2_next = 16'sh8000;
        else
            r2_next = shr0[15:0];
        left    = shift_reg[5] ? 5'd0 : shift_reg[4:0];
        x2_next = p1_reg << left;
    end

    assign mul3_next = 64'(x2_reg) * 64'(mult_reg);

    always_comb
    begin
        neg_shift = 6'd0 - shift_reg;
        right     = shift_reg[5] ? neg_shift[4:0] : 5'd0;
        sum64     = mul3_reg + 64'sh0000_0000_4000_0000;
        q         = sat3_reg ? 32'sh7FFF_FFFF : sum64[62:31];
        rnd1      = (right == 5'd0) ? 33'sd0 : (33'sd1 <<< (right - 5'd1));
        sum1      = {q[31], q} + rnd1;
        shr1      = sum1 >>> right;
        q4_next   = shr1[31:0];
    end

    always_comb
    begin
        w5 = q4_reg + {{24{zp_reg[7]}}, zp_reg};
        out_next.last_out = l4_reg;
        if (m4_reg == MODE_SHIFT16)
            out_next.product_out = r4_reg;
        else if (w5 > 32'sd127)
            out_next.product_out = 16'sd127;
        else if (w5 < -32'sd128)
            out_next.product_out = -16'sd128;
        else
            out_next.product_out = w5[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start && !busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg   <= 32'(operand.lhs) * 32'(operand.rhs);
        l1_reg   <= operand.last_in;
        m1_reg   <= mode_reg;
        x2_reg   <= x2_next;
        r2_reg   <= r2_next;
        l2_reg   <= l1_reg;
        m2_reg   <= m1_reg;
        mul3_reg <= mul3_next;
        sat3_reg <= (x2_reg == 32'sh8000_0000) && (mult_reg == 32'sh8000_0000);
        r3_reg   <= r2_reg;
        l3_reg   <= l2_reg;
        m3_reg   <= m2_reg;
        q4_reg   <= q4_next;
        r4_reg   <= r3_reg;
        l4_reg   <= l3_reg;
        m4_reg   <= m3_reg;
        out_reg  <= out_next;
        l5_reg   <= l4_reg;
    end

    assign result_valid = v5_reg;

    always_comb
    begin
        result          = out_reg;
        result.last_out = l5_reg;
    end

endmodule

FILE: src/imr_checker.sv
// Port-level checker for the int16 multiply-requantize block, with its bind.
// Depends on imr_pkg and int16_multiply_requantize_defines.svh.
`include "int16_multiply_requantize_defines.svh"

module imr_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic                              busy,
    input  imr_pkg::operand_t                 operand,
    input  logic                              result_valid,
    input  imr_pkg::result_t                  result,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [imr_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [imr_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import imr_pkg::*;

    `IMR_ASSERT_DELAY(a_result_follows, start && !busy, 5, result_valid)
    `IMR_ASSERT_IMPLY(a_no_spurious, result_valid, $past(start && !busy, LATENCY))
    `IMR_ASSERT_IMPLY(a_last_kept, result_valid, result.last_out == $past(operand.last_in, LATENCY))

endmodule

bind int16_multiply_requantize imr_checker u_imr_checker (.*);

FILE: test/tb_int16_multiply_requantize.sv
// Self-checking testbench for int16_multiply_requantize: directed and random element pairs
// under many register settings, results checked against an in-bench requantize predictor.
// Depends on imr_pkg and the int16_multiply_requantize RTL.
module tb_int16_multiply_requantize;
    timeunit 1ns;
    timeprecision 1ps;

    import imr_pkg::*;

    localparam int  RANDOM_PHASES   = 12;
    localparam int  ITEMS_PER_PHASE = 142;
    localparam int  CYCLE_LIMIT     = 400000;
    localparam longint Q31_MIN      = -64'sd2147483648;
    localparam longint Q31_MAX      = 64'sd2147483647;
    localparam longint Q31_HALF     = 64'sd1073741824;

    class requant_scoreboard;
        logic               mode;
        logic signed [31:0] mult;
        logic signed [5:0]  shift;
        logic signed [7:0]  zp;
        result_t            expected_q[$];
        int                 errors;

        function new();
            mode   = MODE_SHIFT16;
            mult   = MULT_RESET;
            shift  = '0;
            zp     = '0;
            errors = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
            case (index)
                REG_MODE:  mode  = data[0];
                REG_MULT:  mult  = data;
                REG_SHIFT: shift = data[5:0];
                REG_ZP:    zp    = data[7:0];
                default:   ;
            endcase
        endfunction

        function result_t requantize(operand_t op);
            longint      prod;
            longint      v;
            int          sh;
            int unsigned left;
            int unsigned right;
            logic [31:0] low;
            result_t     r;
            prod = longint'($signed(op.lhs)) * longint'($signed(op.rhs));
            v = prod;
            if (mode == MODE_SHIFT16)
            begin
                right = 32'(shift[4:0]);
                if (right != 0)
                    v = (v + (longint'(1) <<< (right - 1))) >>> right;
                if (v < -32768)
                    v = -32768;
                else if (v > 32767)
                    v = 32767;
            end
            else
            begin
                sh = int'(shift);
                left  = (sh > 0) ? sh : 0;
                right = (sh > 0) ? 0 : -sh;
                left  = left & 31;
                right = right & 31;
                if (left != 0)
                begin
                    low = v[31:0] << left;
                    v = longint'($signed(low));
                end
                if (v == Q31_MIN && longint'(mult) == Q31_MIN)
                    v = Q31_MAX;
                else
                    v = (v * longint'(mult) + Q31_HALF) >>> 31;
                if (right != 0)
                    v = (v + (longint'(1) <<< (right - 1))) >>> right;
                low = v[31:0] + 32'($signed(zp));
                v = longint'($signed(low));
                if (v < -128)
                    v = -128;
                else if (v > 127)
                    v = 127;
            end
            r.product_out = v[15:0];
            r.last_out    = op.last_in;
            return r;
        endfunction

        function void note_operand(operand_t op);
            expected_q.push_back(requantize(op));
        endfunction

        function void check_result(result_t got);
            result_t exp_r;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with none outstanding: product_out %0d",
                       got.product_out);
                errors++;
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.product_out !== exp_r.product_out)
            begin
                $error("product_out: expected %0d, actual %0d",
                       exp_r.product_out, got.product_out);
                errors++;
            end
            if (got.last_out !== exp_r.last_out)
            begin
                $error("last_out: expected %0b, actual %0b", exp_r.last_out, got.last_out);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   start;
    logic                   busy;
    operand_t               operand;
    logic                   result_valid;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    requant_scoreboard board = new();
    int                cycles = 0;

    int16_multiply_requantize uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operand      (operand),
        .result_valid (result_valid),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_operand(operand_t op);
        start   <= 1'b1;
        operand <= op;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_operand(op);
    endtask

    task automatic send_pair(int a, int b, bit last);
        operand_t op;
        op.lhs     = a[15:0];
        op.rhs     = b[15:0];
        op.last_in = last;
        send_operand(op);
    endtask

    task automatic idle_cycles(int n);
        start   <= 1'b0;
        operand <= operand_t'({16'($urandom), 16'($urandom), 1'($urandom)});
        repeat (n)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.write_register(index, data);
    endtask

    // hold off operands until the pipeline is empty, then write every register
    task automatic configure(logic m, logic [31:0] mult, logic [5:0] sh, logic [7:0] zp);
        start <= 1'b0;
        wait_drained();
        write_register(REG_MODE, {31'b0, m});
        write_register(REG_MULT, mult);
        write_register(REG_SHIFT, 32'($signed(sh)));
        write_register(REG_ZP, 32'($signed(zp)));
        cfg_valid <= 1'b0;
    endtask

    function automatic operand_t random_operand();
        operand_t op;
        if ($urandom_range(1) == 0)
        begin
            op.lhs = 16'($urandom);
            op.rhs = 16'($urandom);
        end
        else
        begin
            op.lhs = 16'($signed($urandom_range(510)) - 255);
            op.rhs = 16'($signed($urandom_range(510)) - 255);
        end
        op.last_in = ($urandom_range(15) == 0);
        return op;
    endfunction

    task automatic random_phase(int p);
        logic        m;
        logic [31:0] mult;
        logic [5:0]  sh;
        logic [7:0]  zp;
        int          idle_pct;
        m = 1'($urandom_range(1));
        case ($urandom_range(5))
            0:       mult = 32'h8000_0000;
            1:       mult = 32'h7FFF_FFFF;
            2:       mult = '0;
            3:       mult = $urandom;
            default: mult = $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
        endcase
        if ($urandom_range(1) == 0)
            mult = -mult;
        if ($urandom_range(3) == 0)
            sh = 6'($urandom_range(63));
        else if (m == MODE_MULT8)
            sh = 6'(-int'($urandom_range(24, 8)));
        else
            sh = 6'($urandom_range(16));
        zp = 8'($urandom_range(255));
        if (p == 0)
        begin
            m  = MODE_MULT8;
            sh = 6'sd31;
        end
        else if (p == 1)
        begin
            m  = MODE_SHIFT16;
            sh = 6'sd31;
        end
        case ($urandom_range(3))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            2:       idle_pct = 30;
            default: idle_pct = 60;
        endcase
        if (p == RANDOM_PHASES - 1)
            idle_pct = 0;
        configure(m, mult, sh, zp);
        repeat (ITEMS_PER_PHASE)
        begin
            send_operand(random_operand());
            if ($urandom_range(99) < idle_pct)
                idle_cycles($urandom_range(8, 1));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        start     <= 1'b0;
        operand   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MODE;
        cfg_data  <= '0;
        repeat (4)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_pair(-32768, -32768, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        send_pair(32767, 32767, 1'b0);
        send_pair(0, 0, 1'b1);
        send_pair(-1, 1, 1'b0);

        configure(MODE_SHIFT16, MULT_RESET, 6'sd1, 8'sd0);
        send_pair(3, 1, 1'b0);
        send_pair(-3, 1, 1'b0);
        send_pair(-1, 1, 1'b1);

        configure(MODE_SHIFT16, MULT_RESET, -6'sd1, 8'sd0);
        send_pair(-32768, -32768, 1'b0);
        send_pair(-32768, 32767, 1'b1);

        configure(MODE_MULT8, 32'h8000_0000, 6'sd16, 8'sd0);
        send_pair(-32768, 1, 1'b0);
        send_pair(32767, 1, 1'b1);
        send_pair(-32768, -32768, 1'b0);

        configure(MODE_MULT8, 32'h7FFF_FFFF, 6'b100000, -8'sd128);
        send_pair(-32768, -32768, 1'b0);
        send_pair(200, 1, 1'b1);
        send_pair(-1, -1, 1'b0);

        configure(MODE_MULT8, MULT_RESET, -6'sd31, 8'sd127);
        send_pair(32767, 32767, 1'b1);
        send_pair(-32768, 32767, 1'b0);
        send_pair(0, 0, 1'b0);

        configure(MODE_MULT8, MULT_RESET, -6'sd4, 8'sd5);
        send_pair(16, 1, 1'b0);
        send_pair(-16, 1, 1'b0);
        send_pair(3000, -7, 1'b1);

        for (int p = 0; p < RANDOM_PHASES; p++)
            random_phase(p);

        start <= 1'b0;
        wait_drained();
        repeat (LATENCY + 4)
            @(posedge clk);
        if (board.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+src
src/imr_pkg.sv
src/int16_multiply_requantize.sv
src/imr_checker.sv
test/tb_int16_multiply_requantize.sv
